// ----- src/tcw_pkg.sv -----
// Package for the text console writer: operation and character codes,
// register map of the configuration port, sequencer state and cell fix-up kinds.
// No dependencies.
package tcw_pkg;

    // Widths of the fixed item fields
    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = CHAR_W + ATTR_W;
    localparam int ADDR_W   = 11;
    localparam int OFFSET_W = 11;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'd0;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_TEXT_COLOR   = '0;
    localparam logic [ATTR_W-1:0]     TEXT_COLOR_RESET = 8'd15;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_TOUCH,
        ST_READ,
        ST_SCROLL,
        ST_CLEAR
    } tcw_state_t;

    // Fix-up of the cell under a freshly moved cursor
    typedef enum logic {
        TOUCH_ONLY,
        TOUCH_ERASE
    } tcw_touch_t;

endpackage

// ----- src/tcw_cell_ram.sv -----
// Cell store of the text console writer: simple dual-port RAM, one write and
// one registered read per cycle. No dependencies.
module tcw_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/tcw_apb_regs.sv -----
// Configuration registers of the text console writer behind an APB-style port.
// Depends on tcw_pkg.
module tcw_apb_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output logic [tcw_pkg::ATTR_W-1:0]     text_color
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0]     text_color_reg;
    logic [ATTR_W-1:0]     text_color_next;
    logic [APB_ADDR_W-3:0] reg_index;
    logic                  wr_strobe;

    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign wr_strobe = psel && penable && pwrite;

    always_comb begin
        text_color_next = text_color_reg;
        if (wr_strobe && (reg_index == REG_TEXT_COLOR)) begin
            text_color_next = pwdata[ATTR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= TEXT_COLOR_RESET;
        end else begin
            text_color_reg <= text_color_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_TEXT_COLOR) begin
            prdata = APB_DATA_W'(text_color_reg);
        end
    end

    assign pready     = 1'b1;
    assign text_color = text_color_reg;

endmodule

// ----- src/text_console_writer.sv -----
// Top level of the text console writer: cursor, sequencer and result register
// around the cell store. Depends on tcw_pkg, tcw_cell_ram and tcw_apb_regs.
//
// Usage
//   Input beats (s_*) carry an operation: put character, clear screen or read
//   cell. Every input beat yields exactly one result beat (m_*) holding the
//   cursor offset after the operation and, for a read, the addressed cell.
//   The APB-style port holds text_color, the attribute for written
//   characters and for the cells that a scroll blanks.
// Timing
//   A put that does not scroll and a read in range read the cell store in the
//   accepting cycle; then ST_TOUCH writes the modified cell back and loads
//   the result register for a put, and ST_READ loads it for a read. The
//   registered read of the cell store sets this order. The unused code
//   loads its result in the accepting cycle. A put that scrolls then walks
//   the store and a clear writes every cell, both after the accepting cycle;
//   s_ready is low meanwhile.
// Reset
//   After aresetn rises the block zeroes the cell store, one cell a cycle,
//   with s_ready low; configuration writes are taken.
// Stall
//   A result waits in the output register while m_ready is low; a new beat
//   is taken only once that register is free or being emptied.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tcw_pkg::OP_W-1:0]      s_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]    s_char_code,
    input  logic [tcw_pkg::ADDR_W-1:0]    s_cell_address,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tcw_pkg::OFFSET_W-1:0]  m_cursor_offset,
    output logic [tcw_pkg::CHAR_W-1:0]    m_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]    m_cell_attribute,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW = $clog2(CELL_COUNT);       // cell address
    localparam int SW = $clog2(CELL_COUNT + 1);   // sweep counter
    localparam int CW = $clog2(COLUMNS + 1);      // column, may reach COLUMNS
    localparam int RW = $clog2(ROWS);             // row

    localparam logic [AW-1:0] LAST_CELL      = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] LAST_ROW_BASE  = AW'(CELL_COUNT - COLUMNS);
    localparam logic [AW-1:0] ROW_STRIDE     = AW'(COLUMNS);
    localparam logic [CW-1:0] COL_WRAP       = CW'(COLUMNS);
    localparam logic [CW-1:0] COL_LAST       = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST       = RW'(ROWS - 1);
    localparam logic [RW-1:0] ROW_PENULT     = RW'(ROWS - 2);
    localparam logic [SW-1:0] SWEEP_STRIDE   = SW'(COLUMNS);
    localparam logic [SW-1:0] COPY_LEN       = SW'(CELL_COUNT - COLUMNS);
    localparam logic [SW-1:0] CLEAR_END      = SW'(CELL_COUNT - 1);
    localparam logic [SW-1:0] SCROLL_END     = SW'(CELL_COUNT);

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [ATTR_W-1:0] text_color;

    tcw_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .text_color (text_color)
    );

    // ---------------------------------------------------------------
    // Cell store: {char, attribute} per cell
    // ---------------------------------------------------------------
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    tcw_cell_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (AW),
        .DATA_W (CELL_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    tcw_state_t         state_reg, state_next;
    logic [SW-1:0]      sweep_reg, sweep_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [AW-1:0]      off_reg, off_next;        // row_reg*COLUMNS + col_reg
    logic [AW-1:0]      touch_addr_reg, touch_addr_next;
    tcw_touch_t         touch_kind_reg, touch_kind_next;
    logic               rd_hit_reg, rd_hit_next;

    logic                m_valid_reg, m_valid_next;
    logic [OFFSET_W-1:0] m_offset_reg, m_offset_next;
    logic [CHAR_W-1:0]   m_char_reg, m_char_next;
    logic [ATTR_W-1:0]   m_attr_reg, m_attr_next;
    logic                out_load;
    logic [CHAR_W-1:0]   res_char;
    logic [ATTR_W-1:0]   res_attr;

    logic               accept;
    logic               is_backspace;
    logic               is_newline;
    logic               at_last_row;
    logic               at_last_cell;
    logic               wrap_pending;
    logic               addr_in_range;
    logic [AW-1:0]      nl_off;
    logic [CHAR_W-1:0]  rd_char;
    logic [ATTR_W-1:0]  rd_attr;

    // Take a beat only when the result register is free by the time it loads.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign is_backspace  = (s_char_code == CHAR_BACKSPACE);
    assign is_newline    = (s_char_code == CHAR_NEWLINE);
    assign at_last_row   = (row_reg == ROW_LAST);
    assign at_last_cell  = (off_reg == LAST_CELL);
    assign wrap_pending  = (col_reg == COL_WRAP);
    assign addr_in_range = (int'(s_cell_address) < CELL_COUNT);
    // Start of the next row: advance by the rest of this row.
    assign nl_off        = off_reg + ROW_STRIDE - AW'(col_reg);

    assign rd_char = ram_rdata[CELL_W-1:ATTR_W];
    assign rd_attr = ram_rdata[ATTR_W-1:0];

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (sweep_reg == CLEAR_END) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_operation)
                        OP_PUT: begin
                            if (is_backspace) begin
                                state_next = ST_TOUCH;
                            end else if (is_newline) begin
                                state_next = at_last_row ? ST_SCROLL : ST_TOUCH;
                            end else begin
                                state_next = at_last_cell ? ST_SCROLL : ST_TOUCH;
                            end
                        end
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_READ:  state_next = ST_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TOUCH:  state_next = ST_IDLE;
            ST_READ:   state_next = ST_IDLE;
            ST_SCROLL: begin
                if (sweep_reg == SCROLL_END) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (sweep_reg == CLEAR_END) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs: store accesses, cursor update, result load
    // ---------------------------------------------------------------
    always_comb begin
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        sweep_next      = sweep_reg + SW'(1);
        col_next        = col_reg;
        row_next        = row_reg;
        off_next        = off_reg;
        touch_addr_next = touch_addr_reg;
        touch_kind_next = touch_kind_reg;
        rd_hit_next     = rd_hit_reg;
        out_load        = 1'b0;
        res_char        = '0;
        res_attr        = '0;

        case (state_reg)
            ST_INIT: begin
                // Zero the store after reset.
                ram_we    = 1'b1;
                ram_waddr = AW'(sweep_reg);
            end

            ST_IDLE: begin
                sweep_next = '0;
                if (accept) begin
                    case (s_operation)
                        OP_PUT: begin
                            if (is_backspace) begin
                                // Step back, stop at the origin; erase there next cycle.
                                if (col_reg != '0) begin
                                    col_next = col_reg - CW'(1);
                                end else if (row_reg != '0) begin
                                    col_next = COL_LAST;
                                    row_next = row_reg - RW'(1);
                                end
                                off_next        = (off_reg == '0) ? '0 : off_reg - AW'(1);
                                ram_re          = 1'b1;
                                ram_raddr       = off_next;
                                touch_addr_next = off_next;
                                touch_kind_next = TOUCH_ERASE;
                            end else if (is_newline) begin
                                col_next = '0;
                                if (at_last_row) begin
                                    // Scroll; the blank fill colors the landing cell.
                                    off_next = LAST_ROW_BASE;
                                end else begin
                                    row_next        = row_reg + RW'(1);
                                    off_next        = nl_off;
                                    ram_re          = 1'b1;
                                    ram_raddr       = nl_off;
                                    touch_addr_next = nl_off;
                                    touch_kind_next = TOUCH_ONLY;
                                end
                            end else begin
                                // A pending wrap lands on the same offset: write there.
                                ram_we    = 1'b1;
                                ram_waddr = off_reg;
                                ram_wdata = {s_char_code, text_color};
                                if (at_last_cell) begin
                                    col_next = COL_WRAP;
                                    row_next = ROW_PENULT;
                                    off_next = LAST_ROW_BASE;
                                end else begin
                                    if (wrap_pending) begin
                                        col_next = CW'(1);
                                        row_next = row_reg + RW'(1);
                                    end else begin
                                        col_next = col_reg + CW'(1);
                                    end
                                    off_next        = off_reg + AW'(1);
                                    ram_re          = 1'b1;
                                    ram_raddr       = off_next;
                                    touch_addr_next = off_next;
                                    touch_kind_next = TOUCH_ONLY;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            col_next = '0;
                            row_next = '0;
                            off_next = '0;
                        end
                        OP_READ: begin
                            ram_re      = addr_in_range;
                            ram_raddr   = AW'(s_cell_address);
                            rd_hit_next = addr_in_range;
                        end
                        default: begin
                            // Unused code: report the cursor at once.
                            out_load = 1'b1;
                        end
                    endcase
                end
            end

            ST_TOUCH: begin
                // An empty cell takes the current color; backspace also drops the char.
                ram_we    = 1'b1;
                ram_waddr = touch_addr_reg;
                if (rd_char == CHAR_BLANK) begin
                    ram_wdata = {CHAR_BLANK, text_color};
                end else if (touch_kind_reg == TOUCH_ERASE) begin
                    ram_wdata = {CHAR_BLANK, rd_attr};
                end else begin
                    ram_wdata = ram_rdata;
                end
                out_load = 1'b1;
            end

            ST_READ: begin
                out_load = 1'b1;
                if (rd_hit_reg) begin
                    res_char = rd_char;
                    res_attr = rd_attr;
                end
            end

            ST_SCROLL: begin
                // Read one row ahead and write each cell back in the cycle after its read; blank the last row.
                ram_re    = (sweep_reg < COPY_LEN);
                ram_raddr = AW'(sweep_reg + SWEEP_STRIDE);
                ram_we    = (sweep_reg != '0);
                ram_waddr = AW'(sweep_reg - SW'(1));
                ram_wdata = (sweep_reg <= COPY_LEN) ? ram_rdata : {CHAR_BLANK, text_color};
                out_load  = (sweep_reg == SCROLL_END);
            end

            ST_CLEAR: begin
                // Zero every cell; the origin, under the cursor, takes the color.
                ram_we    = 1'b1;
                ram_waddr = AW'(sweep_reg);
                ram_wdata = (sweep_reg == '0) ? {CHAR_BLANK, text_color} : '0;
                out_load  = (sweep_reg == CLEAR_END);
            end

            default: begin
                sweep_next = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_offset_next = m_offset_reg;
        m_char_next   = m_char_reg;
        m_attr_next   = m_attr_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_offset_next = OFFSET_W'(off_next);
            m_char_next   = res_char;
            m_attr_next   = res_attr;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            sweep_reg      <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            off_reg        <= '0;
            touch_kind_reg <= TOUCH_ONLY;
            rd_hit_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            off_reg        <= off_next;
            touch_kind_reg <= touch_kind_next;
            rd_hit_reg     <= rd_hit_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload: no reset
    always_ff @(posedge aclk) begin
        touch_addr_reg <= touch_addr_next;
        m_offset_reg   <= m_offset_next;
        m_char_reg     <= m_char_next;
        m_attr_reg     <= m_attr_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_cursor_offset  = m_offset_reg;
    assign m_cell_char      = m_char_reg;
    assign m_cell_attribute = m_attr_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result register loaded while a result still waits");

    a_offset_tracks_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(off_reg) == int'(row_reg) * COLUMNS + int'(col_reg))
        else $error("cursor offset out of step with row and column");

    a_cursor_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(off_reg) < CELL_COUNT)
        else $error("cursor offset beyond the cell store");

    a_wrap_not_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg == COL_WRAP) |-> (row_reg != ROW_LAST))
        else $error("wrap pending on the last row");

    a_no_port_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write of the same cell in one cycle");

    a_touch_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TOUCH) |-> $past(ram_re))
        else $error("cell fix-up without a preceding read");

endmodule
